### src/falw_pkg.sv
// Shared types, constants and arithmetic helpers for the feature affinity
// log-weight block. Used by the top level, its port checker and the bench.
// No dependencies.
package falw_pkg;

	localparam int NUM_REGS = 8;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int REG_W    = 16;

	typedef enum logic [2:0] {
		REG_RGB_W     = 3'd0,
		REG_NORMAL_W  = 3'd1,
		REG_DIFFUSE_W = 3'd2,
		REG_REFLECT_W = 3'd3,
		REG_REFRACT_W = 3'd4,
		REG_DEPTH_W   = 3'd5,
		REG_ALBEDO_W  = 3'd6,
		REG_SIGMA     = 3'd7
	} reg_idx_t;

	localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
		16'd512, 16'd768, 16'd256, 16'd512, 16'd256, 16'd512, 16'd512, 16'd128
	};

	localparam int OUT_W      = 41;
	localparam int DIV_W      = 53;
	localparam int DIV_STEPS  = 7;
	localparam int FRONT_STG  = 6;
	localparam int DIV_STG    = 2 * (DIV_STEPS + 1);
	localparam int NSTG       = FRONT_STG + DIV_STG;

	localparam logic [15:0]      SHD_SCALE = 16'd65280;   // 128 * 510
	localparam logic [16:0]      NRM_BIAS  = 17'd65025;
	localparam logic [53:0]      HALF_DEN  = 54'd65025;
	localparam logic [DIV_W-1:0] BYTE_MAX  = DIV_W'(255);
	localparam logic [39:0]      SAT_MAG   = '1;
	localparam logic [OUT_W-1:0] OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

	// one lane of the divide-by-255 chain: q + y/255 stays constant
	typedef struct packed {
		logic             neg;
		logic [DIV_W-1:0] q;
		logic [DIV_W-1:0] y;
	} dv_t;

	function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [17:0] sq_sum3(input logic [23:0] a, input logic [23:0] b);
		logic [17:0] s;
		logic [7:0]  d;
		logic [15:0] d2;
		s = '0;
		for (int i = 0; i < 3; i++) begin
			d  = abs_diff8(a[8*i +: 8], b[8*i +: 8]);
			d2 = d * d;
			s  = s + {2'b00, d2};
		end
		return s;
	endfunction

	// 65025 - sum((2a-255)(2b-255))
	function automatic logic signed [18:0] nrm_term(input logic [23:0] a,
			input logic [23:0] b);
		logic signed [9:0]  ca;
		logic signed [9:0]  cb;
		logic signed [19:0] s;
		s = '0;
		for (int i = 0; i < 3; i++) begin
			ca = $signed({1'b0, a[8*i +: 8], 1'b0}) - 10'sd255;
			cb = $signed({1'b0, b[8*i +: 8], 1'b0}) - 10'sd255;
			s  = s + 20'(ca * cb);
		end
		s = $signed({3'b000, NRM_BIAS}) - s;
		return s[18:0];
	endfunction

	// y = 256h + l  ->  y/255 = h + (h + l)/255
	function automatic dv_t div255_step(input dv_t d);
		dv_t r;
		r.neg = d.neg;
		r.q   = d.q + {8'd0, d.y[DIV_W-1:8]};
		r.y   = {8'd0, d.y[DIV_W-1:8]} + {{(DIV_W-8){1'b0}}, d.y[7:0]};
		return r;
	endfunction

	// after the steps y is below 510
	function automatic logic [DIV_W-1:0] div255_fix(input dv_t d);
		return d.q + {{(DIV_W-1){1'b0}}, (d.y >= BYTE_MAX)};
	endfunction

endpackage

### src/feature_affinity_log_weight.sv
// Pixel-pair log affinity for a feature-guided bilateral range kernel.
// Takes one pair of pixel feature words per cycle and returns the weighted
// feature distance, negated and scaled by sigma_factor, as signed Q24.16,
// rounded to nearest with ties away from zero. Fully pipelined, with a
// throughput of one word per cycle. Five stages form the distance and
// the sigma product; seventeen more round and halve, then divide by 65025 as
// two passes of seven digit-fold steps by 255, each pass closed by a
// correction stage. A stall on the output freezes the
// whole pipeline; in_ready follows out_ready whenever the last stage holds a
// word. Weights sit in an APB register file at byte addresses 0 to 28 and
// must only be changed while the pipeline is empty.
// Depends on falw_pkg.
module feature_affinity_log_weight (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [falw_pkg::ADDR_W-1:0]   paddr,
	input  logic [falw_pkg::DATA_W-1:0]   pwdata,
	output logic [falw_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// pixel pair in
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [23:0]                   a_rgb,
	input  logic [23:0]                   a_normal,
	input  logic [23:0]                   a_material,
	input  logic [7:0]                    a_depth,
	input  logic [7:0]                    a_shadow,
	input  logic [23:0]                   a_albedo,
	input  logic [23:0]                   b_rgb,
	input  logic [23:0]                   b_normal,
	input  logic [23:0]                   b_material,
	input  logic [7:0]                    b_depth,
	input  logic [7:0]                    b_shadow,
	input  logic [23:0]                   b_albedo,
	// affinity out
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [falw_pkg::OUT_W-1:0] log_affinity
);
	import falw_pkg::*;

	logic [REG_W-1:0] cfg_q [NUM_REGS];
	logic [NSTG:1]    vld_s;
	logic             adv;

	// stage 1: feature terms
	logic [17:0]        sq_rgb_s1, sq_alb_s1;
	logic signed [18:0] nrm_s1;
	logic [7:0]         dif_s1, rfl_s1, rfr_s1, dep_s1, shd_s1;
	// stage 2: weighted terms
	logic [33:0]        p_rgb_s2, p_alb_s2;
	logic signed [35:0] p_nrm_s2;
	logic [23:0]        m_dif_s2, m_rfl_s2, m_rfr_s2, m_dep_s2, m_shd_s2;
	// stage 3: partial sums
	logic [35:0]        col2_s3;
	logic [25:0]        mat_s3;
	logic signed [36:0] nsh_s3;
	// stage 4: distance, stage 5: sigma product
	logic signed [37:0] dist_s4;
	logic signed [53:0] prod_s5;
	// stage 6 onwards: divider lanes, index is stage minus six
	dv_t                dv_s [0:DIV_STG-1];
	dv_t                dv_d [1:DIV_STG-1];
	logic signed [OUT_W-1:0] aff_s22;

	logic [34:0]        mat510;
	logic signed [54:0] prod_full;
	logic [53:0]        mag;
	logic [53:0]        rnd;
	dv_t                dv0_d;
	logic [DIV_W-1:0]   q_fin;
	logic [39:0]        q_clamp;
	logic [OUT_W-1:0]   res_d;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				cfg_q[i] <= REG_RESET[i];
		end else if (psel && penable && pwrite) begin
			cfg_q[paddr[ADDR_W-1:2]] <= pwdata[REG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = {{(DATA_W-REG_W){1'b0}}, cfg_q[paddr[ADDR_W-1:2]]};

	// ---------------- flow control ----------------
	assign adv       = !vld_s[NSTG] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (adv)
			vld_s <= {vld_s[NSTG-1:1], in_valid};
	end

	// ---------------- combinational helpers ----------------
	always_comb begin
		mat510    = {mat_s3, 9'd0} - {8'd0, mat_s3, 1'b0};
		prod_full = dist_s4 * $signed({1'b0, cfg_q[REG_SIGMA]});
		mag       = prod_s5[53] ? 54'(-prod_s5) : 54'(prod_s5);
		rnd       = mag + HALF_DEN;
		// halving first: floor(n/130050) = floor(floor(n/2)/65025)
		dv0_d.neg = !prod_s5[53] && (prod_s5 != '0);
		dv0_d.q   = '0;
		dv0_d.y   = rnd[53:1];
	end

	for (genvar k = 1; k < DIV_STG; k++) begin : g_div
		if (k == DIV_STEPS + 1) begin : g_fix
			// end of the first pass: quotient by 255 becomes the next dividend
			always_comb begin
				dv_d[k].neg = dv_s[k-1].neg;
				dv_d[k].q   = '0;
				dv_d[k].y   = div255_fix(dv_s[k-1]);
			end
		end else begin : g_step
			assign dv_d[k] = div255_step(dv_s[k-1]);
		end
	end

	always_comb begin
		q_fin   = div255_fix(dv_s[DIV_STG-1]);
		q_clamp = (q_fin > {{(DIV_W-40){1'b0}}, SAT_MAG}) ? SAT_MAG : q_fin[39:0];
		res_d   = dv_s[DIV_STG-1].neg ? -{1'b0, q_clamp} : {1'b0, q_clamp};
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_rgb_s1 <= sq_sum3(a_rgb, b_rgb);
			sq_alb_s1 <= sq_sum3(a_albedo, b_albedo);
			nrm_s1    <= nrm_term(a_normal, b_normal);
			dif_s1    <= abs_diff8(a_material[23:16], b_material[23:16]);
			rfl_s1    <= abs_diff8(a_material[15:8], b_material[15:8]);
			rfr_s1    <= abs_diff8(a_material[7:0], b_material[7:0]);
			dep_s1    <= abs_diff8(a_depth, b_depth);
			shd_s1    <= abs_diff8(a_shadow, b_shadow);

			p_rgb_s2 <= cfg_q[REG_RGB_W] * sq_rgb_s1;
			p_alb_s2 <= cfg_q[REG_ALBEDO_W] * sq_alb_s1;
			p_nrm_s2 <= $signed({1'b0, cfg_q[REG_NORMAL_W]}) * nrm_s1;
			m_dif_s2 <= cfg_q[REG_DIFFUSE_W] * dif_s1;
			m_rfl_s2 <= cfg_q[REG_REFLECT_W] * rfl_s1;
			m_rfr_s2 <= cfg_q[REG_REFRACT_W] * rfr_s1;
			m_dep_s2 <= cfg_q[REG_DEPTH_W] * dep_s1;
			m_shd_s2 <= SHD_SCALE * shd_s1;

			col2_s3 <= {({1'b0, p_rgb_s2} + {1'b0, p_alb_s2}), 1'b0};
			mat_s3  <= ({2'b00, m_dif_s2} + {2'b00, m_rfl_s2})
				+ ({2'b00, m_rfr_s2} + {2'b00, m_dep_s2});
			nsh_s3  <= {p_nrm_s2[35], p_nrm_s2} + $signed({13'd0, m_shd_s2});

			dist_s4 <= $signed({2'b00, col2_s3}) + {nsh_s3[36], nsh_s3}
				+ $signed({3'b000, mat510});

			prod_s5 <= prod_full[53:0];

			dv_s[0] <= dv0_d;
			for (int k = 1; k < DIV_STG; k++)
				dv_s[k] <= dv_d[k];

			aff_s22 <= res_d;
		end
	end

	assign log_affinity = aff_s22;

endmodule

### src/falw_checker.sv
// Port-level checker for feature_affinity_log_weight, bound to the top level.
// Depends on falw_pkg.
module falw_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [falw_pkg::ADDR_W-1:0]   paddr,
	input  logic [falw_pkg::DATA_W-1:0]   pwdata,
	input  logic [falw_pkg::DATA_W-1:0]   prdata,
	input  logic                          pready,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [falw_pkg::OUT_W-1:0] log_affinity
);
	import falw_pkg::*;

	// a held word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(log_affinity))
		else $error("output word changed while stalled");

	// a stalled output lets nothing new into the pipeline
	a_back_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// saturation keeps the word off the most negative code
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> log_affinity != OUT_MIN)
		else $error("affinity outside saturation range");

	// a register reads back what was last written to it
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(psel && penable && pwrite && pready) && psel && !pwrite
			&& paddr == $past(paddr)
		|-> prdata == {{(DATA_W-REG_W){1'b0}}, $past(pwdata[REG_W-1:0])})
		else $error("register read-back mismatch");

endmodule

bind feature_affinity_log_weight falw_checker u_falw_checker (.*);

### bench/log_affinity_checker.sv
// Checker for the pixel-pair log affinity block: mirrors the weight registers
// from the APB port, predicts each affinity word and compares it on output.
// Depends on falw_pkg.
module log_affinity_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic                              pready,
	input  logic [falw_pkg::ADDR_W-1:0]       paddr,
	input  logic [falw_pkg::DATA_W-1:0]       pwdata,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [23:0]                       a_rgb,
	input  logic [23:0]                       a_normal,
	input  logic [23:0]                       a_material,
	input  logic [7:0]                        a_depth,
	input  logic [7:0]                        a_shadow,
	input  logic [23:0]                       a_albedo,
	input  logic [23:0]                       b_rgb,
	input  logic [23:0]                       b_normal,
	input  logic [23:0]                       b_material,
	input  logic [7:0]                        b_depth,
	input  logic [7:0]                        b_shadow,
	input  logic [23:0]                       b_albedo,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [falw_pkg::OUT_W-1:0] log_affinity,
	output int                                pending,
	output int                                mismatches
);
	timeunit 1ns;
	timeprecision 1ps;
	import falw_pkg::*;

	localparam longint ROUND_HALF = 65025;
	localparam longint DIVISOR    = 130050;
	localparam longint SHADOW_K   = 128 * 510;
	localparam longint CLAMP      = 64'h00FF_FFFF_FFFF;

	logic [REG_W-1:0]        weight [NUM_REGS];
	logic signed [OUT_W-1:0] affinity_due [$];
	logic signed [OUT_W-1:0] oldest;
	int                      bad;

	function automatic longint byte_gap(input logic [7:0] x, input logic [7:0] y);
		longint xv;
		longint yv;
		xv = x;
		yv = y;
		return (xv > yv) ? xv - yv : yv - xv;
	endfunction

	function automatic longint square_gap(input logic [23:0] x, input logic [23:0] y);
		longint s;
		longint d;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			d = byte_gap(x[8*i +: 8], y[8*i +: 8]);
			s += d * d;
		end
		return s;
	endfunction

	function automatic logic signed [OUT_W-1:0] predict_affinity(
			input logic [23:0] ar, input logic [23:0] an, input logic [23:0] am,
			input logic [7:0] ad, input logic [7:0] as, input logic [23:0] aa,
			input logic [23:0] br, input logic [23:0] bn, input logic [23:0] bm,
			input logic [7:0] bd, input logic [7:0] bs, input logic [23:0] ba);
		longint w_rgb, w_nrm, w_dif, w_rfl, w_rfr, w_dep, w_alb, sigma;
		longint distance, dot, ca, cb, prod, mag, q;
		w_rgb = weight[REG_RGB_W];
		w_nrm = weight[REG_NORMAL_W];
		w_dif = weight[REG_DIFFUSE_W];
		w_rfl = weight[REG_REFLECT_W];
		w_rfr = weight[REG_REFRACT_W];
		w_dep = weight[REG_DEPTH_W];
		w_alb = weight[REG_ALBEDO_W];
		sigma = weight[REG_SIGMA];
		dot = 0;
		for (int i = 0; i < 3; i++) begin
			ca = an[8*i +: 8];
			cb = bn[8*i +: 8];
			dot += (2 * ca - 255) * (2 * cb - 255);
		end
		// distance scaled by 2*255*255*256 so that every term is whole
		distance = 2 * w_rgb * square_gap(ar, br)
			+ w_nrm * (65025 - dot)
			+ 510 * (w_dif * byte_gap(am[23:16], bm[23:16])
				+ w_rfl * byte_gap(am[15:8], bm[15:8])
				+ w_rfr * byte_gap(am[7:0], bm[7:0])
				+ w_dep * byte_gap(ad, bd))
			+ SHADOW_K * byte_gap(as, bs)
			+ 2 * w_alb * square_gap(aa, ba);
		prod = distance * sigma;
		mag  = (prod < 0) ? -prod : prod;
		q    = (mag + ROUND_HALF) / DIVISOR;
		if (q > CLAMP)
			q = CLAMP;
		if (prod > 0)
			q = -q;
		return q[OUT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				weight[i] <= REG_RESET[i];
			affinity_due.delete();
			bad = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			if (psel && penable && pwrite && pready)
				weight[paddr[ADDR_W-1:2]] <= pwdata[REG_W-1:0];
			if (in_valid && in_ready)
				affinity_due.push_back(predict_affinity(a_rgb, a_normal, a_material,
					a_depth, a_shadow, a_albedo, b_rgb, b_normal, b_material,
					b_depth, b_shadow, b_albedo));
			if (out_valid && out_ready) begin
				if (affinity_due.size() == 0) begin
					if (bad < 10)
						$display("%t: unexpected affinity word %0d", $realtime, log_affinity);
					bad++;
				end else begin
					oldest = affinity_due.pop_front();
					if (log_affinity !== oldest) begin
						if (bad < 10)
							$display("%t: log_affinity expected %0d got %0d",
								$realtime, oldest, log_affinity);
						bad++;
					end
				end
			end
			pending <= affinity_due.size();
			mismatches <= bad;
		end
	end

endmodule

### bench/feature_affinity_log_weight_tb.sv
// Testbench top for feature_affinity_log_weight: drives pixel pairs and APB
// weight writes, stalls both channels at random, and gives the verdict.
// Depends on falw_pkg, the block and log_affinity_checker.
module feature_affinity_log_weight_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import falw_pkg::*;

	localparam int SETTLE_CYCLES = 32;

	typedef struct packed {
		logic [23:0] a_rgb;
		logic [23:0] a_normal;
		logic [23:0] a_material;
		logic [7:0]  a_depth;
		logic [7:0]  a_shadow;
		logic [23:0] a_albedo;
		logic [23:0] b_rgb;
		logic [23:0] b_normal;
		logic [23:0] b_material;
		logic [7:0]  b_depth;
		logic [7:0]  b_shadow;
		logic [23:0] b_albedo;
	} pixel_pair_t;

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [DATA_W-1:0]       pwdata;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    in_valid;
	logic                    in_ready;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [OUT_W-1:0] log_affinity;
	pixel_pair_t             pair_word;
	int                      pending;
	int                      mismatches;
	bit                      quiet = 1'b0;

	logic [23:0] a_rgb, a_normal, a_material, a_albedo;
	logic [23:0] b_rgb, b_normal, b_material, b_albedo;
	logic [7:0]  a_depth, a_shadow, b_depth, b_shadow;

	assign a_rgb      = pair_word.a_rgb;
	assign a_normal   = pair_word.a_normal;
	assign a_material = pair_word.a_material;
	assign a_depth    = pair_word.a_depth;
	assign a_shadow   = pair_word.a_shadow;
	assign a_albedo   = pair_word.a_albedo;
	assign b_rgb      = pair_word.b_rgb;
	assign b_normal   = pair_word.b_normal;
	assign b_material = pair_word.b_material;
	assign b_depth    = pair_word.b_depth;
	assign b_shadow   = pair_word.b_shadow;
	assign b_albedo   = pair_word.b_albedo;

	feature_affinity_log_weight u_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_ready, .a_rgb, .a_normal, .a_material, .a_depth, .a_shadow,
		.a_albedo, .b_rgb, .b_normal, .b_material, .b_depth, .b_shadow, .b_albedo,
		.out_valid, .out_ready, .log_affinity
	);

	log_affinity_checker u_checker (
		.clk, .arst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.in_valid, .in_ready, .a_rgb, .a_normal, .a_material, .a_depth, .a_shadow,
		.a_albedo, .b_rgb, .b_normal, .b_material, .b_depth, .b_shadow, .b_albedo,
		.out_valid, .out_ready, .log_affinity, .pending, .mismatches
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// output back-pressure in bursts; none once the run goes quiet
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (quiet || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	function automatic logic [23:0] nudge24(input logic [23:0] v);
		logic [23:0] r;
		for (int i = 0; i < 3; i++)
			r[8*i +: 8] = v[8*i +: 8] + 8'($urandom_range(0, 6)) - 8'd3;
		return r;
	endfunction

	// each byte at a rail or anywhere
	function automatic logic [23:0] rail24();
		logic [23:0] r;
		for (int i = 0; i < 3; i++)
			case ($urandom_range(0, 2))
				0:       r[8*i +: 8] = 8'h00;
				1:       r[8*i +: 8] = 8'hFF;
				default: r[8*i +: 8] = 8'($urandom);
			endcase
		return r;
	endfunction

	function automatic logic [15:0] rail16();
		case ($urandom_range(0, 3))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(0, 1023));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic pixel_pair_t same_pixel();
		pixel_pair_t p;
		p = pixel_pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom});
		p.b_rgb      = p.a_rgb;
		p.b_normal   = p.a_normal;
		p.b_material = p.a_material;
		p.b_depth    = p.a_depth;
		p.b_shadow   = p.a_shadow;
		p.b_albedo   = p.a_albedo;
		return p;
	endfunction

	function automatic pixel_pair_t random_pair();
		pixel_pair_t p;
		p = pixel_pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom});
		case ($urandom_range(0, 9))
			3, 4, 5: begin
				// neighbouring pixels: small differences, small affinities
				p.b_rgb      = nudge24(p.a_rgb);
				p.b_normal   = nudge24(p.a_normal);
				p.b_material = nudge24(p.a_material);
				p.b_depth    = 8'(nudge24({16'd0, p.a_depth}));
				p.b_shadow   = 8'(nudge24({16'd0, p.a_shadow}));
				p.b_albedo   = nudge24(p.a_albedo);
			end
			6: p = same_pixel();
			7, 8, 9: begin
				p.a_rgb      = rail24();
				p.a_normal   = rail24();
				p.a_material = rail24();
				p.a_depth    = 8'(rail24());
				p.a_shadow   = 8'(rail24());
				p.a_albedo   = rail24();
				p.b_rgb      = rail24();
				p.b_normal   = rail24();
				p.b_material = rail24();
				p.b_depth    = 8'(rail24());
				p.b_shadow   = 8'(rail24());
				p.b_albedo   = rail24();
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_weights(input logic [REG_W-1:0] w [NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(reg_idx_t'(i), w[i]);
	endtask

	task automatic roll_weights(output logic [REG_W-1:0] w [NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++)
			w[i] = rail16();
	endtask

	// valid stays up into the next word unless an idle burst is drawn
	task automatic send_pair(input pixel_pair_t p);
		in_valid  <= 1'b1;
		pair_word <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic send_random(input int n);
		repeat (n)
			send_pair(random_pair());
	endtask

	// wait for the pipe to empty before touching the weights
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_corners();
		pixel_pair_t p;
		send_pair('0);
		send_pair({{112{1'b1}}, {112{1'b0}}});
		send_pair({{112{1'b0}}, {112{1'b1}}});
		send_pair(same_pixel());
		// normals pointing the same way decode longer than unit: positive result
		p = same_pixel();
		p.a_normal = 24'hFFFFFF;
		p.b_normal = 24'hFFFFFF;
		send_pair(p);
		p.a_normal = 24'h000000;
		p.b_normal = 24'h000000;
		send_pair(p);
		// opposite normals: largest normal term
		p.a_normal = 24'hFFFFFF;
		send_pair(p);
		p.a_normal = 24'h808080;
		p.b_normal = 24'h7F7F7F;
		send_pair(p);
		p = same_pixel();
		p.a_shadow = 8'hFF;
		p.b_shadow = 8'h00;
		send_pair(p);
		p = same_pixel();
		p.a_depth = 8'h00;
		p.b_depth = 8'hFF;
		send_pair(p);
		for (int i = 0; i < 3; i++) begin
			p = same_pixel();
			p.a_material = 24'hFF << (8 * i);
			p.b_material = 24'h000000;
			send_pair(p);
		end
		p = same_pixel();
		p.a_rgb = 24'hFF0000;
		p.b_rgb = 24'h000000;
		send_pair(p);
		p = same_pixel();
		p.a_rgb = 24'h0000FF;
		p.b_rgb = 24'hFFFF00;
		send_pair(p);
		p = same_pixel();
		p.a_albedo = 24'h00FF00;
		p.b_albedo = 24'h000000;
		send_pair(p);
	endtask

	initial begin : stimulus
		logic [REG_W-1:0] w [NUM_REGS];
		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		in_valid  <= 1'b0;
		pair_word <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_corners();
		drain();

		for (int i = 0; i < NUM_REGS; i++)
			w[i] = '1;
		write_weights(w);
		send_corners();
		send_random(60);
		drain();

		for (int i = 0; i < NUM_REGS; i++)
			w[i] = '0;
		write_weights(w);
		send_random(30);
		drain();

		roll_weights(w);
		w[REG_SIGMA] = 16'd1;
		write_weights(w);
		send_random(120);
		drain();

		// normal weight at its maximum, so same-facing normals can give positive words
		for (int i = 0; i < NUM_REGS; i++)
			w[i] = 16'($urandom_range(0, 255));
		w[REG_NORMAL_W] = '1;
		w[REG_SIGMA]    = rail16();
		write_weights(w);
		send_random(80);
		drain();

		repeat (4) begin
			roll_weights(w);
			write_weights(w);
			send_random(100);
			drain();
		end

		quiet = 1'b1;
		roll_weights(w);
		write_weights(w);
		send_random(100);
		drain();

		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### feature_affinity_log_weight.f
src/falw_pkg.sv
src/feature_affinity_log_weight.sv
src/falw_checker.sv
bench/log_affinity_checker.sv
bench/feature_affinity_log_weight_tb.sv
